[rtl/pat_pkg.sv]
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the page attribute table
// Field widths, operation and status codes, register indexes and the
// controller state type used by the table and its attribute memory.
// ----------------------------------------------------------------------------
package pat_pkg;

    // Widths fixed by the beat fields.
    localparam int ADDR_W     = 48;
    localparam int PCNT_W     = 13;
    localparam int ACC_W      = 3;
    localparam int ATTR_W     = 4;
    localparam int RUN_W      = 25;
    localparam int STAT_W     = 2;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;

    // Page geometry.
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 4096;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_FLAGS = 2'd1,
        OP_RUN   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_CONFLICT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_FLAG,
        S_WALK,
        S_RESULT
    } t_state;

endpackage

[rtl/pat_ram.sv]
// ----------------------------------------------------------------------------
// pat_ram: attribute memory
// One entry of page attributes per page; one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module pat_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [pat_pkg::ATTR_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [pat_pkg::ATTR_W-1:0] o_rdata
);
    import pat_pkg::*;

    logic [ATTR_W-1:0] r_mem [DEPTH];
    logic [ATTR_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/page_attribute_table.sv]
// ----------------------------------------------------------------------------
// page_attribute_table: per-page attribute table of a loaded image
// Marks segment spans with page attributes, answers page flag queries and
// counts same-attribute runs, walking the attribute memory page by page.
// ----------------------------------------------------------------------------
// An empty, out-of-range or unknown request goes straight from the range check
// to the result; a flag query reads one page, and a mark or run query walks the
// pages it covers, one page read a cycle.
// A new request is accepted the cycle after the previous result enters the
// output register. After reset a clearing pass zeroes the memory before the
// first request is accepted.
module page_attribute_table #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: address[47:0], end_address[95:48], access[98:96], max_pages[111:99]
    input  logic [pat_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [pat_pkg::OP_W-1:0]         s_axis_tuser,
    // Result channel.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: attributes[3:0], run_bytes[28:4], status[30:29], zero fill[31]
    output logic [pat_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [pat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pat_pkg::ADDR_W-1:0]       i_cfg_data
);
    import pat_pkg::*;

    localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_RQ = $clog2(MAX_PAGES + 1);
    localparam int CNT_W  = (CNT_RQ > PCNT_W) ? CNT_RQ : PCNT_W;
    localparam int TOP_W  = ADDR_W + 1;

    // Control state.
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr;
    logic                 r_rd_vld;
    logic                 r_out_vld;
    logic [ADDR_W-1:0]    r_cfg_base;
    logic [PCNT_W-1:0]    r_cfg_pcnt;

    // Request and working registers.
    t_op                  r_op;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_end;
    logic [ACC_W-1:0]     r_access;
    logic [PCNT_W-1:0]    r_maxp;
    logic [ADDR_W-1:0]    r_off;
    logic [ADDR_W-1:0]    r_eoff;
    logic [CNT_W-1:0]     r_pg;
    logic [CNT_W-1:0]     r_lim;
    logic [IDX_W-1:0]     r_chk;
    logic [ATTR_W-1:0]    r_res_attr;
    logic [RUN_W-1:0]     r_res_run;
    t_status              r_res_status;
    logic [ATTR_W-1:0]    r_out_attr;
    logic [RUN_W-1:0]     r_out_run;
    t_status              r_out_status;

    // Combinational signals.
    logic                 c_in_ready;
    logic                 c_clear;
    logic                 c_walk;
    logic                 c_result;
    logic                 in_beat;
    logic [CNT_W-1:0]     pages_eff;
    logic [TOP_W-1:0]     top;
    logic [ATTR_W-1:0]    flags;
    logic                 seg_empty;
    logic                 below_base;
    logic                 end_over;
    logic                 addr_over;
    logic                 chk_done;
    t_status              chk_status;
    logic [CNT_W-1:0]     off_page;
    logic [CNT_W-1:0]     mark_pe;
    logic                 low_nz;
    logic [CNT_W-1:0]     run_next;
    logic [CNT_W:0]       run_sum;
    logic [CNT_W-1:0]     run_last;
    logic [ATTR_W-1:0]    ram_rdata;
    logic                 mismatch;
    logic                 more;
    logic                 walk_issue;
    logic                 walk_end;
    logic                 res_load;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ATTR_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;

    // Effective page count and top of the image range.
    always_comb begin
        pages_eff = (CNT_W'(r_cfg_pcnt) > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                             : CNT_W'(r_cfg_pcnt);
        top       = {1'b0, r_cfg_base} + (TOP_W'(pages_eff) << PAGE_SHIFT);
    end

    // Range checks on the captured request.
    always_comb begin
        flags      = {r_access, 1'b1};
        seg_empty  = (r_end <= r_addr);
        below_base = (r_addr < r_cfg_base);
        end_over   = ({1'b0, r_end} > top);
        addr_over  = ({1'b0, r_addr} >= top);
        case (r_op) inside
            OP_MARK: begin
                chk_done   = seg_empty || below_base || end_over;
                chk_status = (!seg_empty && (below_base || end_over)) ? STAT_RANGE
                                                                      : STAT_OK;
            end
            OP_FLAGS, OP_RUN: begin
                chk_done   = below_base || addr_over;
                chk_status = (below_base || addr_over) ? STAT_RANGE : STAT_OK;
            end
            default: begin
                chk_done   = 1'b1;
                chk_status = STAT_OK;
            end
        endcase
    end

    // Walk bounds from the page offsets.
    always_comb begin
        off_page = r_off[PAGE_SHIFT +: CNT_W];
        mark_pe  = r_eoff[PAGE_SHIFT +: CNT_W] + CNT_W'(|r_eoff[PAGE_SHIFT-1:0]);
        low_nz   = |r_off[PAGE_SHIFT-1:0];
        run_next = off_page + CNT_W'(low_nz);
        run_sum  = (CNT_W+1)'(run_next) + (CNT_W+1)'(r_maxp);
        run_last = (run_sum > {1'b0, pages_eff}) ? pages_eff : run_sum[CNT_W-1:0];
    end

    // Page walk: read one page a cycle, check the page read the cycle before.
    always_comb begin
        if (r_op == OP_MARK) begin
            mismatch = (ram_rdata != '0) && (ram_rdata != r_res_attr);
        end else begin
            mismatch = (ram_rdata != r_res_attr);
        end
        more       = (r_pg < r_lim);
        walk_issue = c_walk && more && !(r_rd_vld && mismatch);
        walk_end   = (r_rd_vld && mismatch) || !more;
        res_load   = c_result && (!r_out_vld || m_axis_tready);
        in_beat    = s_axis_tvalid && c_in_ready;
    end

    // Memory port selection.
    always_comb begin
        if (c_clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = c_walk && r_rd_vld && !mismatch && (r_op == OP_MARK);
            ram_waddr = r_chk;
            ram_wdata = r_res_attr;
        end
        ram_raddr = (r_state == S_SETUP) ? off_page[IDX_W-1:0] : r_pg[IDX_W-1:0];
    end

    pat_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == IDX_W'(MAX_PAGES - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_beat) n_state = S_CHECK;
            S_CHECK:  n_state = chk_done ? S_RESULT : S_SETUP;
            S_SETUP:  n_state = (r_op == OP_MARK) ? S_WALK : S_FLAG;
            S_FLAG:   n_state = (r_op == OP_RUN) ? S_WALK : S_RESULT;
            S_WALK:   if (walk_end) n_state = S_RESULT;
            S_RESULT: if (res_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State decode.
    always_comb begin
        c_in_ready = 1'b0;
        c_clear    = 1'b0;
        c_walk     = 1'b0;
        c_result   = 1'b0;
        unique case (r_state)
            S_CLEAR:  c_clear    = 1'b1;
            S_IDLE:   c_in_ready = 1'b1;
            S_WALK:   c_walk     = 1'b1;
            S_RESULT: c_result   = 1'b1;
            default:  ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_cfg_base <= '0;
            r_cfg_pcnt <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= walk_issue;
            if (c_clear) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE:  r_cfg_base <= {i_cfg_data[ADDR_W-1:PAGE_SHIFT],
                                              PAGE_SHIFT'(0)};
                    CFG_PAGES: r_cfg_pcnt <= i_cfg_data[PCNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op     <= t_op'(s_axis_tuser);
            r_addr   <= s_axis_tdata[47:0];
            r_end    <= s_axis_tdata[95:48];
            r_access <= s_axis_tdata[98:96];
            r_maxp   <= s_axis_tdata[111:99];
        end
        unique case (r_state)
            S_CHECK: begin
                r_off        <= r_addr - r_cfg_base;
                r_eoff       <= r_end - r_cfg_base;
                r_res_run    <= '0;
                r_res_attr   <= (r_op == OP_MARK) ? flags : '0;
                r_res_status <= chk_status;
            end
            S_SETUP: begin
                if (r_op == OP_MARK) begin
                    r_pg  <= off_page;
                    r_lim <= mark_pe;
                end else begin
                    r_pg  <= run_next;
                    r_lim <= run_last;
                end
                // A run that starts inside a page counts what is left of it.
                if (r_op == OP_RUN && low_nz) begin
                    r_res_run <= RUN_W'(PAGE_BYTES) - RUN_W'(r_off[PAGE_SHIFT-1:0]);
                end
            end
            S_FLAG: begin
                r_res_attr <= ram_rdata;
            end
            S_WALK: begin
                if (walk_issue) begin
                    r_chk <= r_pg[IDX_W-1:0];
                    r_pg  <= r_pg + CNT_W'(1);
                end
                if (r_rd_vld) begin
                    if (mismatch) begin
                        if (r_op == OP_MARK) begin
                            r_res_status <= STAT_CONFLICT;
                        end
                    end else if (r_op == OP_RUN) begin
                        r_res_run <= r_res_run + RUN_W'(PAGE_BYTES);
                    end
                end
            end
            default: ;
        endcase
        if (res_load) begin
            r_out_attr   <= r_res_attr;
            r_out_run    <= r_res_run;
            r_out_status <= r_res_status;
        end
    end

    assign s_axis_tready = c_in_ready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_status, r_out_run, r_out_attr};

    // Checks.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK))
        else $error("accepted request did not enter the range check");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_pg <= r_lim))
        else $error("page walk ran past its limit");

    a_conflict_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_status == STAT_CONFLICT) |-> r_out_attr[0])
        else $error("conflict result without mapped attributes");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_out_vld && !s_axis_tready))
        else $error("traffic during the clearing pass");

endmodule
